// ===== rtl/rnbp_pkg.sv =====
// Package for the row nonzero-count bucket partitioner: widths, codes, beat types, helpers.
package rnbp_pkg;

  // Width of the nonzero count held internally, and of the local row index.
  localparam int COUNT_WIDTH = 32;
  localparam int ROW_WIDTH   = 32;

  // The count taken from a 32-bit field cannot be wider than the field.
  localparam int CNT_W  = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
  // Window bounds: a 32-bit bound times a factor of at most 256 stays below 2^40.
  localparam int BND_W  = 40;
  localparam int CFG_W  = 32;
  localparam int RATE_W = 9;
  localparam int IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_WINDOW_BASE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW_CAP    = 2'd1;
  localparam logic [IDX_W-1:0] REG_GROWTH_FACTOR = 2'd2;

  // Reset values of the registers.
  localparam logic [CFG_W-1:0]  BASE_RESET = 32'd32;
  localparam logic [CFG_W-1:0]  CAP_RESET  = 32'd1024;
  localparam logic [RATE_W-1:0] RATE_RESET = 9'd2;

  // Growth factor limits.
  localparam logic [RATE_W-1:0] RATE_MIN = 9'd2;
  localparam logic [RATE_W-1:0] RATE_MAX = 9'd256;

  typedef struct packed {
    logic [31:0] row_count;
    logic        last_row;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] block_end_row;
    logic        final_block;
  } out_beat_t;

  // Request from the sequencer to the window search unit.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } search_req_t;

  // Status and result of the window search unit.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [BND_W-1:0] low;
    logic [BND_W-1:0] high;
  } search_sts_t;

  // Row index to the 32-bit output field, zero-extended or truncated.
  function automatic logic [31:0] row_to_out(input logic [ROW_WIDTH-1:0] v);
    logic [ROW_WIDTH+31:0] ext;
    ext = {32'd0, v};
    return ext[31:0];
  endfunction

endpackage

// ===== rtl/rnbp_window_search.sv =====
// Iterative window search: one compare and one 32x9 multiply per cycle, holds the window.
module rnbp_window_search (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [rnbp_pkg::CFG_W-1:0]      base,
  input  logic [rnbp_pkg::CFG_W-1:0]      cap,
  input  logic [rnbp_pkg::RATE_W-1:0]     rate,
  input  rnbp_pkg::search_req_t           req,
  output rnbp_pkg::search_sts_t           sts
);

  logic [rnbp_pkg::BND_W-1:0]  lo_r, lo_nxt;
  logic [rnbp_pkg::BND_W-1:0]  hi_r, hi_nxt;
  logic [rnbp_pkg::BND_W-1:0]  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        capm_r, capm_nxt;
  logic                        grown_r, grown_nxt;
  logic [rnbp_pkg::BND_W-1:0]  cap_ext;
  logic [rnbp_pkg::BND_W-1:0]  base_eff;
  logic [rnbp_pkg::BND_W-1:0]  req_cnt;
  logic [rnbp_pkg::RATE_W-1:0] rate_eff;
  logic [rnbp_pkg::CFG_W+rnbp_pkg::RATE_W-1:0] prod;
  logic                        step;

  assign cap_ext  = {{(rnbp_pkg::BND_W-rnbp_pkg::CFG_W){1'b0}}, cap};
  assign req_cnt  = {{(rnbp_pkg::BND_W-rnbp_pkg::CNT_W){1'b0}}, req.count};

  // A zero base acts as one; the factor is clamped into its legal range.
  assign base_eff = (base == '0) ? {{(rnbp_pkg::BND_W-1){1'b0}}, 1'b1}
                                 : {{(rnbp_pkg::BND_W-rnbp_pkg::CFG_W){1'b0}}, base};
  always_comb begin
    priority if (rate < rnbp_pkg::RATE_MIN) begin
      rate_eff = rnbp_pkg::RATE_MIN;
    end else if (rate > rnbp_pkg::RATE_MAX) begin
      rate_eff = rnbp_pkg::RATE_MAX;
    end else begin
      rate_eff = rate;
    end
  end

  // Shared multiplier: the bound is at most the cap whenever a step is taken.
  assign prod = hi_r[rnbp_pkg::CFG_W-1:0] * rate_eff;

  // Grow while the count reaches the bound and the bound has not passed the cap.
  // The window above the cap takes exactly one multiply and is then final.
  assign step = capm_r || (!grown_r && (cnt_r >= hi_r) && (hi_r <= cap_ext));

  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    capm_nxt  = capm_r;
    grown_nxt = grown_r;
    if (req.start) begin
      cnt_nxt   = req_cnt;
      busy_nxt  = 1'b1;
      grown_nxt = 1'b0;
      if (req_cnt >= cap_ext) begin
        lo_nxt   = cap_ext;
        hi_nxt   = cap_ext;
        capm_nxt = 1'b1;
      end else begin
        lo_nxt   = '0;
        hi_nxt   = base_eff;
        capm_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (step) begin
        if (!capm_r) begin
          lo_nxt = hi_r;
        end else begin
          grown_nxt = 1'b1;
        end
        hi_nxt   = prod[rnbp_pkg::BND_W-1:0];
        capm_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r    <= '0;
      hi_r    <= '0;
      busy_r  <= 1'b0;
      capm_r  <= 1'b0;
      grown_r <= 1'b0;
    end else begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      busy_r  <= busy_nxt;
      capm_r  <= capm_nxt;
      grown_r <= grown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

  assign sts = '{busy: busy_r, done: busy_r && !step, low: lo_r, high: hi_r};

endmodule

// ===== rtl/row_nnz_bucket_partitioner_core.sv =====
// Top level of the row nonzero-count bucket partitioner: registers, sequencer, result beats.
//
//   Channel  Direction  Handshake         Payload
//   in_      input      in_valid/in_ready  rnbp_pkg::in_beat_t (row_count, last_row)
//   out_     output     out_valid/out_ready rnbp_pkg::out_beat_t (block_end_row, final_block)
//   cfg_     input      cfg_we             cfg_index, cfg_data (write only)
//
// A row whose count stays in the current window needs no search; a last row goes on to its final beat.
// A row that opens a block or leaves its window runs the window search, one growth step of
// the shared multiplier at a time, until the window holds the count or has outgrown the cap.
// Synchronous active-low reset restores the register defaults and closes any block.
// A full output register stalls the sequencer only in its emit states; in_ready is high only
// in the idle state, so it is low while a search runs or result beats wait to be loaded.
module row_nnz_bucket_partitioner_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rnbp_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rnbp_pkg::out_beat_t         out_data,
  input  logic                        cfg_we,
  input  logic [rnbp_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rnbp_pkg::CFG_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_BREAK  = 4'b0100,
    ST_FINAL  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [rnbp_pkg::CFG_W-1:0]      base_r, cap_r;
  logic [rnbp_pkg::RATE_W-1:0]     rate_r;
  logic [rnbp_pkg::ROW_WIDTH-1:0]  row_r, row_nxt;
  logic                            open_r, open_nxt;
  logic                            brk_r, brk_nxt;
  logic                            last_r, last_nxt;
  logic [31:0]                     brk_val_r, brk_val_nxt;
  logic [31:0]                     fin_val_r, fin_val_nxt;
  logic                            out_valid_r, out_valid_nxt;
  rnbp_pkg::out_beat_t             out_beat_r, out_beat_nxt;

  rnbp_pkg::search_req_t           req;
  rnbp_pkg::search_sts_t           sts;

  logic                            accept;
  logic [rnbp_pkg::CNT_W-1:0]      count;
  logic [rnbp_pkg::BND_W-1:0]      count_ext, cap_ext;
  logic                            in_win;
  logic                            need_brk;
  logic [rnbp_pkg::ROW_WIDTH-1:0]  idx;
  logic                            slot_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= rnbp_pkg::BASE_RESET;
      cap_r  <= rnbp_pkg::CAP_RESET;
      rate_r <= rnbp_pkg::RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rnbp_pkg::REG_WINDOW_BASE:   base_r <= cfg_data;
        rnbp_pkg::REG_WINDOW_CAP:    cap_r  <= cfg_data;
        rnbp_pkg::REG_GROWTH_FACTOR: rate_r <= cfg_data[rnbp_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Incoming count and the window test against the held window.
  assign accept    = in_valid && in_ready;
  assign count     = in_data.row_count[rnbp_pkg::CNT_W-1:0];
  assign count_ext = {{(rnbp_pkg::BND_W-rnbp_pkg::CNT_W){1'b0}}, count};
  assign cap_ext   = {{(rnbp_pkg::BND_W-rnbp_pkg::CFG_W){1'b0}}, cap_r};
  assign in_win    = ((count_ext >= sts.low) && (count_ext < sts.high)) ||
                     ((count_ext >= sts.high) && (sts.high > cap_ext));
  assign need_brk  = open_r && !in_win;
  assign idx       = open_r ? row_r : '0;

  assign req = '{start: accept && (!open_r || need_brk), count: count};

  rnbp_window_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .base  (base_r),
    .cap   (cap_r),
    .rate  (rate_r),
    .req   (req),
    .sts   (sts)
  );

  assign slot_free = !out_valid_r || out_ready;

  // Sequencer: accept, optional search, then the break beat and the final beat, each when needed.
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    open_nxt      = open_r;
    brk_nxt       = brk_r;
    last_nxt      = last_r;
    brk_val_nxt   = brk_val_r;
    fin_val_nxt   = fin_val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_beat_nxt  = out_beat_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          brk_nxt     = need_brk;
          last_nxt    = in_data.last_row;
          brk_val_nxt = rnbp_pkg::row_to_out(row_r - 1'b1);
          fin_val_nxt = rnbp_pkg::row_to_out(idx);
          if (in_data.last_row) begin
            open_nxt = 1'b0;
            row_nxt  = '0;
          end else begin
            open_nxt = 1'b1;
            row_nxt  = idx + 1'b1;
          end
          priority if (req.start) begin
            state_nxt = ST_SEARCH;
          end else if (in_data.last_row) begin
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SEARCH: begin
        if (sts.done) begin
          priority if (brk_r) begin
            state_nxt = ST_BREAK;
          end else if (last_r) begin
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BREAK: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_beat_nxt.block_end_row = brk_val_r;
          out_beat_nxt.final_block   = 1'b0;
          state_nxt = last_r ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_beat_nxt.block_end_row = fin_val_r;
          out_beat_nxt.final_block   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    brk_r      <= brk_nxt;
    last_r     <= last_nxt;
    brk_val_r  <= brk_val_nxt;
    fin_val_r  <= fin_val_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the row nonzero-count bucket partitioner core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ROWS     = 105;
  localparam int NUM_PHASES     = 11;
  localparam int NUM_DIRECTED   = 16;

  // One row of the directed table; the expected beats are used only when pinned is set.
  typedef struct {
    logic [31:0] cnt;
    logic        last;
    bit          pinned;
    int          n;
    logic [31:0] end0;
    logic        fin0;
    logic [31:0] end1;
    logic        fin1;
  } directed_row_t;

  // What the monitor should expect for one accepted input beat.
  typedef struct {
    bit                  pinned;
    int                  n;
    rnbp_pkg::out_beat_t b0;
    rnbp_pkg::out_beat_t b1;
  } row_note_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  rnbp_pkg::in_beat_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  rnbp_pkg::out_beat_t           out_data;
  logic                          cfg_we = 1'b0;
  logic [rnbp_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [rnbp_pkg::CFG_W-1:0]    cfg_data = '0;

  // Shadow copy of the registers and of the partitioner state.
  logic [31:0]         base_reg = 32'd32;
  logic [31:0]         cap_reg = 32'd1024;
  logic [8:0]          rate_reg = 9'd2;
  logic [63:0]         win_lo = '0;
  logic [63:0]         win_hi = '0;
  logic [31:0]         row_idx = '0;
  bit                  block_open = 1'b0;

  rnbp_pkg::out_beat_t pending_ends[$];
  rnbp_pkg::out_beat_t pred_beats[$];
  row_note_t           row_notes[$];

  int                  errors = 0;
  int                  rows_sent = 0;
  int                  beats_seen = 0;
  int                  finals_seen = 0;
  int                  settings_used = 1;
  int                  idle_cycles = 0;
  int                  hold_off = 0;
  bit                  calm = 1'b0;
  logic [31:0]         prev_count = '0;

  rnbp_pkg::out_beat_t exp_beat;
  row_note_t           cur_note;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 1, 32'd0, 1'b1, 32'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1, 32'd0, 1'b1, 32'd0, 1'b0},
    '{32'd5,         1'b0, 1'b1, 0, 32'd0, 1'b0, 32'd0, 1'b0},
    '{32'd31,        1'b0, 1'b1, 0, 32'd0, 1'b0, 32'd0, 1'b0},
    '{32'd32,        1'b0, 1'b1, 1, 32'd1, 1'b0, 32'd0, 1'b0},
    '{32'd63,        1'b0, 1'b0, 0, 32'd0, 1'b0, 32'd0, 1'b0},
    '{32'd1023,      1'b0, 1'b1, 1, 32'd3, 1'b0, 32'd0, 1'b0},
    '{32'd1024,      1'b0, 1'b1, 1, 32'd4, 1'b0, 32'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 0, 32'd0, 1'b0, 32'd0, 1'b0},
    '{32'd2047,      1'b0, 1'b0, 0, 32'd0, 1'b0, 32'd0, 1'b0},
    '{32'd0,         1'b1, 1'b1, 2, 32'd7, 1'b0, 32'd8, 1'b1},
    '{32'd100,       1'b0, 1'b0, 0, 32'd0, 1'b0, 32'd0, 1'b0},
    '{32'd100,       1'b1, 1'b1, 1, 32'd1, 1'b1, 32'd0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 0, 32'd0, 1'b0, 32'd0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 0, 32'd0, 1'b0, 32'd0, 1'b0},
    '{32'd1,         1'b1, 1'b1, 2, 32'd1, 1'b0, 32'd2, 1'b1}
  };

  row_nnz_bucket_partitioner_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // A zero base acts as one.
  function automatic logic [63:0] eff_base();
    return (base_reg == 32'd0) ? 64'd1 : {32'd0, base_reg};
  endfunction

  // The growth factor is clamped to the range two to 256.
  function automatic logic [63:0] eff_rate();
    if (rate_reg < rnbp_pkg::RATE_MIN) return 64'd2;
    if (rate_reg > rnbp_pkg::RATE_MAX) return 64'd256;
    return {55'd0, rate_reg};
  endfunction

  // Load the window that holds the count into the shadow state.
  task automatic seek_window(input logic [63:0] cnt);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] r;
    r = eff_rate();
    if (cnt < cap_reg) begin
      lo = 64'd0;
      hi = eff_base();
      while (cnt >= hi && hi <= cap_reg) begin
        lo = hi;
        hi = hi * r;
      end
      win_lo = lo;
      win_hi = hi;
    end else begin
      win_lo = cap_reg;
      win_hi = cap_reg * r;
    end
  endtask

  // Counts above a window that has outgrown the cap stay in it.
  function automatic bit fits_window(input logic [63:0] cnt);
    if (cnt >= win_lo && cnt < win_hi) return 1'b1;
    return (cnt >= win_hi) && (win_hi > cap_reg);
  endfunction

  // Work out the end-index beats caused by one row and append them to pred_beats.
  task automatic partition_row(input logic [31:0] cnt, input logic last);
    logic [63:0]         wide;
    rnbp_pkg::out_beat_t b;
    wide = {32'd0, cnt};
    if (!block_open) begin
      row_idx = '0;
      block_open = 1'b1;
      seek_window(wide);
    end else if (!fits_window(wide)) begin
      b = '{block_end_row: row_idx - 32'd1, final_block: 1'b0};
      pred_beats = {pred_beats, b};
      seek_window(wide);
    end
    if (last) begin
      b = '{block_end_row: row_idx, final_block: 1'b1};
      pred_beats = {pred_beats, b};
      block_open = 1'b0;
      row_idx = '0;
    end else begin
      row_idx = row_idx + 32'd1;
    end
  endtask

  // Print one line per mismatch and count them all.
  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Choose a count near the window bounds of the current settings, or anywhere at all.
  function automatic logic [31:0] pick_count();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] r;
    logic [63:0] c;
    int          steps;
    int          i;
    r = eff_rate();
    lo = 64'd0;
    hi = eff_base();
    steps = $urandom_range(0, 40);
    for (i = 0; i < steps && hi <= cap_reg; i++) begin
      lo = hi;
      hi = hi * r;
    end
    case ($urandom_range(0, 9))
      0: c = {32'd0, $urandom};
      1: c = lo;
      2: c = hi - 64'd1;
      3: c = hi;
      4: c = {32'd0, cap_reg} + $urandom_range(0, 3) - 64'd1;
      default: c = lo + ({$urandom, $urandom} % (hi - lo));
    endcase
    if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
    return c[31:0];
  endfunction

  // Offer one row beat after a random gap and wait until it is taken.
  task automatic send_row(input logic [31:0] cnt, input logic last, input row_note_t note);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    row_notes = {row_notes, note};
    in_valid <= 1'b1;
    in_data <= '{row_count: cnt, last_row: last};
    rows_sent++;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Write one register; the shadow copy follows at once since the block is idle.
  task automatic write_reg(input logic [rnbp_pkg::IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      rnbp_pkg::REG_WINDOW_BASE:   base_reg = val;
      rnbp_pkg::REG_WINDOW_CAP:    cap_reg = val;
      rnbp_pkg::REG_GROWTH_FACTOR: rate_reg = val[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every expected beat, then let any window search still running finish.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_ends.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: a random stall before each beat, plus one long hold when asked.
  initial begin : receiver
    int total;
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      total = (calm ? 0 : $urandom_range(0, 7)) + hold_off;
      hold_off = 0;
      if (total > 0) begin
        out_ready <= 1'b0;
        repeat (total) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Check each result beat against the oldest expectation, then predict for each row beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (out_data.final_block === 1'b1) finals_seen++;
        if (pending_ends.size() == 0) begin
          note_mismatch($sformatf("unexpected beat end=%0d final=%0b",
                                  out_data.block_end_row, out_data.final_block));
        end else begin
          exp_beat = pending_ends.pop_front();
          if (out_data.block_end_row !== exp_beat.block_end_row)
            note_mismatch($sformatf("block_end_row %0d, expected %0d",
                                    out_data.block_end_row, exp_beat.block_end_row));
          if (out_data.final_block !== exp_beat.final_block)
            note_mismatch($sformatf("final_block %0b, expected %0b",
                                    out_data.final_block, exp_beat.final_block));
        end
      end
      if (in_valid && in_ready) begin
        cur_note = row_notes.pop_front();
        pred_beats = {};
        partition_row(in_data.row_count, in_data.last_row);
        if (cur_note.pinned) begin
          if (cur_note.n > 0) pending_ends = {pending_ends, cur_note.b0};
          if (cur_note.n > 1) pending_ends = {pending_ends, cur_note.b1};
        end else begin
          foreach (pred_beats[k]) pending_ends = {pending_ends, pred_beats[k]};
        end
      end
    end
  end

  // Watchdog: too long without any beat moving ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then phases of random rows under several settings.
  initial begin : stimulus
    logic [31:0] phase_base [NUM_PHASES];
    logic [31:0] phase_cap  [NUM_PHASES];
    logic [8:0]  phase_rate [NUM_PHASES];
    row_note_t   note;
    logic [31:0] cnt;
    logic        last;
    int          p;
    int          i;

    // Fixed settings first: zero base, widest cap, cap below base, factors out of range.
    phase_base = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd7, 32'd3, 32'd16, 32'd32,
                   32'd0, 32'd0, 32'd0};
    phase_cap  = '{32'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd10, 32'd5000, 32'd100000,
                   32'd4096, 32'd1024, 32'd0, 32'd0, 32'd0};
    phase_rate = '{9'd3, 9'd2, 9'd256, 9'd5, 9'd0, 9'd1, 9'd511, 9'd2, 9'd0, 9'd0, 9'd0};
    for (p = 8; p < NUM_PHASES; p++) begin
      phase_base[p] = $urandom_range(1, 3) == 1 ? $urandom : $urandom_range(1, 5000);
      phase_cap[p]  = phase_base[p] + $urandom_range(0, 1 << 20);
      if (phase_cap[p] < phase_base[p]) phase_cap[p] = 32'hFFFF_FFFF;
      phase_rate[p] = $urandom_range(0, 511);
    end

    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows under the reset settings.
    for (i = 0; i < NUM_DIRECTED; i++) begin
      note.pinned = directed_rows[i].pinned;
      note.n = directed_rows[i].n;
      note.b0 = '{block_end_row: directed_rows[i].end0, final_block: directed_rows[i].fin0};
      note.b1 = '{block_end_row: directed_rows[i].end1, final_block: directed_rows[i].fin1};
      send_row(directed_rows[i].cnt, directed_rows[i].last, note);
    end
    drain();

    // Random rows: half repeat the previous count so blocks grow long.
    note = '{pinned: 1'b0, n: 0, b0: '0, b1: '0};
    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(rnbp_pkg::REG_WINDOW_BASE, phase_base[p]);
      write_reg(rnbp_pkg::REG_WINDOW_CAP, phase_cap[p]);
      write_reg(rnbp_pkg::REG_GROWTH_FACTOR, {23'd0, phase_rate[p]});
      settings_used++;
      calm = (p % 3 == 1);
      if (p == 7) hold_off = HOLD_CYCLES;
      for (i = 0; i < PHASE_ROWS; i++) begin
        cnt = $urandom_range(0, 1) ? prev_count : pick_count();
        last = ($urandom_range(0, 11) == 0);
        prev_count = cnt;
        send_row(cnt, last, note);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_ends.size() != 0)
      note_mismatch($sformatf("%0d expected beats never arrived", pending_ends.size()));

    $display("Sent %0d rows under %0d register settings; %0d end-index beats, %0d final.",
             rows_sent, settings_used, beats_seen, finals_seen);
    $display("Included a long result-side hold, idle-free stretches and clamped factors.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
